// ----- rtl/wbps_pkg.sv -----
// shared constants, types and helper functions of the wildcard byte pattern scanner
`default_nettype none

package wbps_pkg;

  // window depth and derived widths
  localparam int PatternMax  = 16;
  localparam int LenW        = $clog2(PatternMax + 1);
  localparam int IdxW        = $clog2(PatternMax);
  localparam int SigRegBytes = 16;
  localparam int SigW        = 8 * SigRegBytes;

  // item and register widths
  localparam int ByteW    = 8;
  localparam int CountW   = 32;
  localparam int CfgW     = 64;
  localparam int CfgIdxW  = 2;
  localparam int LengthW  = 5;

  // configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CfgPatternLow    = 2'd0,
    CfgPatternHigh   = 2'd1,
    CfgPatternLength = 2'd2
  } cfg_reg_e;

  // per-cell control: the shift is common to the row, active and sig are per cell
  typedef struct packed {
    logic             shift;
    logic             active;
    logic [ByteW-1:0] sig;
  } cell_ctrl_t;

  // length in use: zero acts as one, large values saturate to the window depth
  function automatic logic [LenW-1:0] eff_len(input logic [LengthW-1:0] len);
    logic [LenW-1:0] res;
    if (len == '0) begin
      res = LenW'(1);
    end else if (int'(len) > PatternMax) begin
      res = LenW'(PatternMax);
    end else begin
      res = LenW'(len);
    end
    return res;
  endfunction

  // signature byte by position, bytes past the register pair are wildcards
  function automatic logic [ByteW-1:0] sig_byte(input logic [SigW-1:0] sig,
                                                input logic [IdxW-1:0] idx);
    logic [ByteW-1:0] res;
    logic [SigW-1:0]  shifted;
    shifted = sig >> (ByteW * int'(idx));
    if (int'(idx) < SigRegBytes) begin
      res = shifted[ByteW-1:0];
    end else begin
      res = '0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/wbps_cell.sv -----
// one window cell: holds a byte, passes it on and checks it against its signature byte
`default_nettype none

module wbps_cell (
  input  logic                     clk_i,
  input  wbps_pkg::cell_ctrl_t     ctrl_i,
  input  logic [wbps_pkg::ByteW-1:0] byte_i,
  output logic [wbps_pkg::ByteW-1:0] byte_o,
  output logic                     match_o
);
  import wbps_pkg::*;

  logic [ByteW-1:0] byte_d;
  logic [ByteW-1:0] byte_q;

  // shift the neighbor's byte in on every accepted item while the byte count is below its limit
  assign byte_d = ctrl_i.shift ? byte_i : byte_q;

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign byte_o = byte_q;

  // compare against the byte this cell will hold after the shift
  assign match_o = !ctrl_i.active || (ctrl_i.sig == '0) || (ctrl_i.sig == byte_i);

endmodule

`default_nettype wire

// ----- rtl/wildcard_byte_pattern_scan_top.sv -----
// top level of the scanner: configuration registers, cell row, byte counter and result register
`default_nettype none

// Scans a byte stream for a signature of up to 16 bytes in which a zero byte
// matches anything. One item is taken every clock cycle while the input is not
// stalled; a row of 16 cells shifts the window by one byte per item and compares
// all positions at once, so the result of an item sits in the output register in
// the cycle after it was taken. The input stalls only while a result is held and
// the output stalls. Each image gives one result: found with the start offset at
// the first match, or not found on the last byte. There is no start-up pass after reset.
module wildcard_byte_pattern_scan_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [wbps_pkg::ByteW-1:0]   in_image_byte_i,
  input  logic                         in_image_last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         out_found_o,
  output logic [wbps_pkg::CountW-1:0]  out_match_offset_o,
  input  logic                         cfg_we_i,
  input  logic [wbps_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [wbps_pkg::CfgW-1:0]    cfg_wdata_i
);
  import wbps_pkg::*;

  logic [CfgW-1:0]    pat_low_q, pat_low_d;
  logic [CfgW-1:0]    pat_high_q, pat_high_d;
  logic [LengthW-1:0] pat_len_q, pat_len_d;

  logic [CountW-1:0] seen_q, seen_d;
  logic              latch_q, latch_d;
  logic              out_valid_q, out_valid_d;
  logic              out_found_q, out_found_d;
  logic [CountW-1:0] out_offset_q, out_offset_d;

  logic              accept;
  logic              at_limit;
  logic [LenW-1:0]   len;
  logic [LenW-1:0]   len_m1;
  logic              enough;
  logic              hit;
  logic              emit_found;
  logic              emit_none;
  logic [CountW-1:0] offset;
  logic [SigW-1:0]   sig_all;

  cell_ctrl_t        cell_ctrl [PatternMax];
  logic [ByteW-1:0]  cell_in   [PatternMax];
  logic [ByteW-1:0]  cell_out  [PatternMax];
  logic [PatternMax-1:0] cell_match;

  // configuration registers
  always_comb begin
    pat_low_d  = pat_low_q;
    pat_high_d = pat_high_q;
    pat_len_d  = pat_len_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgPatternLow:    pat_low_d  = cfg_wdata_i;
        CfgPatternHigh:   pat_high_d = cfg_wdata_i;
        CfgPatternLength: pat_len_d  = cfg_wdata_i[LengthW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_low_q  <= '0;
      pat_high_q <= '0;
      pat_len_q  <= LengthW'(1);
    end else begin
      pat_low_q  <= pat_low_d;
      pat_high_q <= pat_high_d;
      pat_len_q  <= pat_len_d;
    end
  end

  // handshake and window status
  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign at_limit   = (seen_q == '1);
  assign len        = eff_len(pat_len_q);
  assign len_m1     = len - LenW'(1);
  assign sig_all    = {pat_high_q, pat_low_q};

  // row of window cells, cell k holds the byte k items back
  for (genvar k = 0; k < PatternMax; k++) begin : g_cell
    logic [LenW-1:0] pos;
    assign pos = LenW'(k);
    assign cell_ctrl[k].shift  = accept && !at_limit;
    assign cell_ctrl[k].active = (pos < len);
    assign cell_ctrl[k].sig    = sig_byte(sig_all, IdxW'(len_m1 - pos));

    if (k == 0) begin : g_head
      assign cell_in[k] = in_image_byte_i;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end

    wbps_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl[k]),
      .byte_i  (cell_in[k]),
      .byte_o  (cell_out[k]),
      .match_o (cell_match[k])
    );
  end

  // match decision on the window as it stands after this item
  assign enough     = (seen_q >= CountW'(len_m1));
  assign hit        = !at_limit && enough && (&cell_match);
  assign offset     = seen_q - CountW'(len_m1);
  assign emit_found = hit && !latch_q;
  assign emit_none  = in_image_last_i && !latch_q && !emit_found;

  // byte counter and found latch, cleared by the last byte
  always_comb begin
    seen_d  = seen_q;
    latch_d = latch_q;
    if (accept) begin
      if (in_image_last_i) begin
        seen_d  = '0;
        latch_d = 1'b0;
      end else begin
        if (!at_limit) begin
          seen_d = seen_q + CountW'(1);
        end
        latch_d = latch_q || hit;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q  <= '0;
      latch_q <= 1'b0;
    end else begin
      seen_q  <= seen_d;
      latch_q <= latch_d;
    end
  end

  // result register
  always_comb begin
    out_valid_d  = out_valid_q;
    out_found_d  = out_found_q;
    out_offset_d = out_offset_q;
    if (accept && (emit_found || emit_none)) begin
      out_valid_d  = 1'b1;
      out_found_d  = emit_found;
      out_offset_d = emit_found ? offset : '0;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_found_q  <= out_found_d;
    out_offset_q <= out_offset_d;
  end

  assign out_valid_o        = out_valid_q;
  assign out_found_o        = out_found_q;
  assign out_match_offset_o = out_offset_q;

  // checks
  a_latch_needs_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    latch_q |-> (seen_q != '0))
    else $error("found latch set with empty byte count");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && in_image_last_i |=> (seen_q == '0) && !latch_q)
    else $error("last byte did not clear the scan state");

  a_found_sets_latch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && emit_found && !in_image_last_i |=> latch_q)
    else $error("reported match did not set the latch");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_q)
    else $error("input stalled with empty result register");

  a_limit_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && at_limit && !in_image_last_i |=> at_limit)
    else $error("byte count left its limit");

endmodule

`default_nettype wire
